[hdl/arx_plant_model_step_macros.svh]
// Assertion macros used by the ARX plant model top level.
`ifndef ARX_PLANT_MODEL_STEP_MACROS_SVH
`define ARX_PLANT_MODEL_STEP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ARX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("arx: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ARX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("arx: next-cycle check failed");

`endif

[hdl/arx_pkg.sv]
// Package: widths, register indexes, reset values and result type of the ARX plant model.
`default_nettype none

package arx_pkg;

  localparam int unsigned SampleW    = 32;  // Q16.16 samples
  localparam int unsigned CoefW      = 20;  // Q4.16 weights
  localparam int unsigned LimitW     = 31;  // Q15.16 magnitude
  localparam int unsigned FracW      = 16;
  localparam int unsigned NumOutCoef = 3;   // output taps that have a weight register
  localparam int unsigned OutTapsDef = 3;

  // config port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = LimitW;

  localparam logic [CfgIdxW-1:0] CfgCoefOut0  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgCoefOut1  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgCoefOut2  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgCoefIn0   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDriveLim  = 3'd4;

  localparam logic [CoefW-1:0]  CoefOut0Rst  = 20'd58982;  // ~0.9
  localparam logic [CoefW-1:0]  CoefOutNRst  = 20'd0;
  localparam logic [CoefW-1:0]  CoefIn0Rst   = 20'd65536;  // 1.0
  localparam logic [LimitW-1:0] DriveLimRst  = 31'd393216; // 6.0

  typedef struct packed {
    logic signed [SampleW-1:0] y;
    logic                      sat;
  } mac_res_t;

endpackage

`default_nettype wire

[hdl/arx_mac.sv]
// Weighted sum of output history and clamped drive, rounded and saturated to Q16.16.
`default_nettype none

module arx_mac #(
  parameter int unsigned OutTaps = arx_pkg::OutTapsDef
) (
  input  logic signed [arx_pkg::SampleW-1:0] hist_i     [OutTaps],
  input  logic signed [arx_pkg::CoefW-1:0]   coef_out_i [arx_pkg::NumOutCoef],
  input  logic signed [arx_pkg::CoefW-1:0]   coef_in_i,
  input  logic signed [arx_pkg::SampleW-1:0] drive_i,
  output arx_pkg::mac_res_t                  res_o
);
  import arx_pkg::*;

  localparam int unsigned ProdW = SampleW + CoefW;
  localparam int unsigned AccW  = ProdW + $clog2(OutTaps + 1) + 1;
  localparam int unsigned RndW  = AccW - FracW + 1;

  localparam logic signed [AccW:0]   HalfLsb = (AccW+1)'(2 ** (FracW - 1));
  localparam logic signed [RndW-1:0] YMax =
    {{(RndW-SampleW+1){1'b0}}, {(SampleW-1){1'b1}}};
  localparam logic signed [RndW-1:0] YMin =
    {{(RndW-SampleW+1){1'b1}}, {(SampleW-1){1'b0}}};

  logic signed [ProdW-1:0] prod [OutTaps+1];
  logic signed [AccW-1:0]  acc;
  logic signed [AccW:0]    biased;
  logic signed [RndW-1:0]  rnd;

  // taps past the weight registers carry zero weight
  for (genvar i = 0; i < OutTaps; i++) begin : g_tap
    if (i < NumOutCoef) begin : g_w
      assign prod[i] = coef_out_i[i] * hist_i[i];
    end else begin : g_z
      assign prod[i] = '0;
    end
  end

  assign prod[OutTaps] = coef_in_i * drive_i;

  always_comb begin
    acc = '0;
    for (int i = 0; i <= OutTaps; i++) begin
      acc = acc + AccW'(prod[i]);
    end
  end

  // round half up, then floor
  assign biased = (AccW+1)'(acc) + HalfLsb;
  assign rnd    = signed'(biased[AccW:FracW]);

  always_comb begin
    res_o.sat = 1'b0;
    res_o.y   = rnd[SampleW-1:0];
    if (rnd > YMax) begin
      res_o.y   = YMax[SampleW-1:0];
      res_o.sat = 1'b1;
    end else if (rnd < YMin) begin
      res_o.y   = YMin[SampleW-1:0];
      res_o.sat = 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/arx_plant_model_step.sv]
// Top level of the ARX plant model: drive clamp, history, config registers, handshakes.
//
// Usage:
//   Input channel: one drive sample per beat (in_valid_i / in_stall_o).
//   Output channel: one result per beat (out_valid_o / out_stall_i) carrying
//   the new plant output, the clamped drive and the saturation flag.
//   Config channel: cfg_valid_i / cfg_ready_o with a register index and data;
//   ready is always high, writes to indexes 5..7 are dropped. Write config
//   only while no beat is in flight.
//   Path: input beat to output valid via the clamp register, then the result
//   register. Throughput: one beat per cycle unless the output stalls, set by
//   the combinational multiply-accumulate feeding output history into the next sum.
//   Stall: while the output is stalled one more input beat is taken into the
//   input register; after that in_stall_o follows out_stall_i.
//   Reset: histories clear to zero, weights and limit take their defaults,
//   both pipeline stages empty. No clearing pass.
`default_nettype none
`include "arx_plant_model_step_macros.svh"

module arx_plant_model_step #(
  parameter int unsigned OutTaps = arx_pkg::OutTapsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input beats
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [arx_pkg::SampleW-1:0] drive_value_i,
  // result beats
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [arx_pkg::SampleW-1:0] plant_output_o,
  output logic signed [arx_pkg::SampleW-1:0] applied_drive_o,
  output logic                               output_saturated_o,
  // config writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [arx_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [arx_pkg::CfgDataW-1:0]       cfg_data_i
);
  import arx_pkg::*;

  // config registers
  logic signed [CoefW-1:0]  coef_out_q [NumOutCoef];
  logic signed [CoefW-1:0]  coef_in_q;
  logic        [LimitW-1:0] lim_q;

  // stage 1: clamped drive
  logic                     in_vld_q;
  logic signed [SampleW-1:0] drv_q, drv_d;

  // stage 2: result register
  logic                      out_vld_q;
  logic signed [SampleW-1:0] out_y_q;
  logic signed [SampleW-1:0] out_drv_q;
  logic                      out_sat_q;

  // output delay line, entry 0 newest
  logic signed [SampleW-1:0] hist_q [OutTaps];

  logic signed [SampleW:0] lim_ext, lim_neg, drv_ext;
  logic                    advance, fire;
  mac_res_t                mac_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_out_q[0] <= signed'(CoefOut0Rst);
      for (int i = 1; i < NumOutCoef; i++) coef_out_q[i] <= signed'(CoefOutNRst);
      coef_in_q     <= signed'(CoefIn0Rst);
      lim_q         <= DriveLimRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgCoefOut0: coef_out_q[0] <= signed'(cfg_data_i[CoefW-1:0]);
        CfgCoefOut1: coef_out_q[1] <= signed'(cfg_data_i[CoefW-1:0]);
        CfgCoefOut2: coef_out_q[2] <= signed'(cfg_data_i[CoefW-1:0]);
        CfgCoefIn0:  coef_in_q     <= signed'(cfg_data_i[CoefW-1:0]);
        CfgDriveLim: lim_q         <= cfg_data_i[LimitW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // symmetric clamp, compared one bit wider so -limit always fits
  assign lim_ext = signed'({2'b00, lim_q});
  assign lim_neg = -lim_ext;
  assign drv_ext = (SampleW+1)'(drive_value_i);

  always_comb begin
    drv_d = drive_value_i;
    if (drv_ext > lim_ext) begin
      drv_d = lim_ext[SampleW-1:0];
    end else if (drv_ext < lim_neg) begin
      drv_d = lim_neg[SampleW-1:0];
    end
  end

  // the result register frees up when empty or when its beat leaves
  assign advance    = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      drv_q <= drv_d;
    end
  end

  arx_mac #(
    .OutTaps (OutTaps)
  ) u_mac (
    .hist_i     (hist_q),
    .coef_out_i (coef_out_q),
    .coef_in_i  (coef_in_q),
    .drive_i    (drv_q),
    .res_o      (mac_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      for (int i = 0; i < OutTaps; i++) hist_q[i] <= '0;
    end else begin
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
      if (fire) begin
        for (int i = OutTaps - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
        hist_q[0] <= mac_res.y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_y_q   <= mac_res.y;
      out_drv_q <= drv_q;
      out_sat_q <= mac_res.sat;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign plant_output_o     = out_y_q;
  assign applied_drive_o    = out_drv_q;
  assign output_saturated_o = out_sat_q;

  // a ready item with a free result slot shows up on the output next cycle
  `ARX_ASSERT_NXT(a_fire_out, clk_i, rst_ni, fire, out_vld_q)
  // the pending result is the newest history entry
  `ARX_ASSERT_IMP(a_hist_head, clk_i, rst_ni, out_vld_q, hist_q[0] == out_y_q)
  // a flagged result sits on a rail
  `ARX_ASSERT_IMP(a_sat_rail, clk_i, rst_ni, out_vld_q && out_sat_q, (out_y_q == {1'b0, {(SampleW-1){1'b1}}}) || (out_y_q == {1'b1, {(SampleW-1){1'b0}}}))
  // applied drive stays within the configured limit
  `ARX_ASSERT_IMP(a_drv_lim, clk_i, rst_ni, out_vld_q, ((SampleW+1)'(out_drv_q) <= lim_ext) && ((SampleW+1)'(out_drv_q) >= lim_neg))

endmodule

`default_nettype wire
